// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/hcb_pkg.sv =====
// Package for the Huffman code builder: fixed field widths, the channel beat
// types and the sequencer state type. No dependencies.
package hcb_pkg;
	localparam int SYM_W  = 4;
	localparam int CODE_W = 15;
	localparam int LEN_W  = 4;
	localparam int IN_WEIGHT_W = 16;

	typedef struct packed {
		logic [IN_WEIGHT_W-1:0] weight;
		logic                   last;
	} in_beat_t;

	typedef struct packed {
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_len;
		logic              last_code;
	} out_beat_t;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_CLR   = 7'b0000010,
		ST_SCAN  = 7'b0000100,
		ST_MERGE = 7'b0001000,
		ST_WALK  = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_WAIT  = 7'b1000000
	} bk_state_t;
endpackage

// ===== rtl/hcb_if.sv =====
// Valid/ready channel interface for the Huffman code builder.
// Depends on hcb_pkg for payload types.
interface hcb_in_if;
	logic valid;
	logic ready;
	hcb_pkg::in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hcb_out_if;
	logic valid;
	logic ready;
	hcb_pkg::out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/hcb_front.sv =====
// Front end: accepts leaf weight beats, saturates them and queues them.
// Depends on hcb_pkg and hcb_if.
module hcb_front #(
	parameter int WEIGHT_BITS = 16,
	parameter int QDEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	hcb_in_if.sink in_ch,
	output logic                   q_valid,
	input  logic                   q_pop,
	output logic [WEIGHT_BITS-1:0] q_weight,
	output logic                   q_last
);
	import hcb_pkg::*;
	localparam int AW = $clog2(QDEPTH);
	localparam int SW = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;

	logic [WEIGHT_BITS-1:0] w_q [QDEPTH];
	logic                   l_q [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          push;
	logic [WEIGHT_BITS-1:0] sat;

	always_comb begin
		sat = '0;
		if (IN_WEIGHT_W > WEIGHT_BITS && (in_ch.data.weight >> SW) != '0)
			sat = '1;
		else
			sat[SW-1:0] = in_ch.data.weight[SW-1:0];
	end

	assign in_ch.ready = (cnt_q != (AW+1)'(QDEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != '0);
	assign q_weight = w_q[rp_q];
	assign q_last = l_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			w_q[wp_q] <= sat;
			l_q[wp_q] <= in_ch.data.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

// ===== rtl/hcb_back.sv =====
// Back end: stores leaves, merges the two lightest nodes per step and
// walks each leaf to the root to emit its code. Depends on hcb_pkg, hcb_if.
module hcb_back #(
	parameter int MAX_SYMBOLS = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  logic [WEIGHT_BITS-1:0] q_weight,
	input  logic                   q_last,
	hcb_out_if.source out_ch
);
	import hcb_pkg::*;
	localparam int NCAP = 2 * MAX_SYMBOLS - 1;
	localparam int NW = $clog2(NCAP + 1);
	localparam int CW = $clog2(MAX_SYMBOLS + 1);
	localparam int SUMW = WEIGHT_BITS + CW;

	bk_state_t st_q;
	logic [SUMW-1:0] wt_q [NCAP];
	logic [NW-1:0]   par_q [NCAP];
	logic [NW-1:0]   left_q [NCAP];
	logic [CW-1:0]   cnt_q, n_q;
	logic [NW-1:0]   nxt_q, idx_q, a_q, b_q, cur_q;
	logic            ha_q, hb_q;
	logic [SUMW-1:0] wa_q, wb_q;
	logic [CODE_W-1:0] code_q;
	logic [5:0]        len_q;
	logic [CW-1:0]     leaf_q;
	out_beat_t         ob_q;
	logic              ov_q;
	logic [NW-1:0]     up;
	logic [SUMW-1:0]   wi;
	logic              free_i;

	assign q_pop = (st_q == ST_LOAD) && q_valid;
	assign out_ch.valid = ov_q;
	assign out_ch.data = ob_q;
	assign up = par_q[cur_q[NW-1:0]];
	assign wi = wt_q[idx_q];
	assign free_i = (par_q[idx_q] == '0);

	always_ff @(posedge clk) begin
		if (q_pop && cnt_q != CW'(MAX_SYMBOLS))
			wt_q[cnt_q] <= SUMW'(q_weight);
		if (st_q == ST_MERGE) begin
			wt_q[nxt_q] <= wa_q + wb_q;
			left_q[nxt_q] <= a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			cnt_q <= '0;
			n_q <= '0;
			ov_q <= 1'b0;
			for (int k = 0; k < NCAP; k++) par_q[k] <= '0;
		end else begin
			if (ov_q && out_ch.ready && st_q != ST_EMIT) ov_q <= 1'b0;
			unique case (st_q)
				ST_LOAD: begin
					if (q_pop) begin
						logic [CW-1:0] c;
						c = (cnt_q != CW'(MAX_SYMBOLS)) ? cnt_q + 1'b1 : cnt_q;
						if (q_last) begin
							cnt_q <= '0;
							n_q <= c;
							idx_q <= '0;
							if (c != '0) st_q <= ST_CLR;
						end else begin
							cnt_q <= c;
						end
					end
				end
				ST_CLR: begin
					par_q[idx_q] <= '0;
					if (idx_q == NW'(NCAP - 1)) begin
						nxt_q <= NW'(n_q);
						idx_q <= '0;
						ha_q <= 1'b0;
						hb_q <= 1'b0;
						if (n_q == CW'(1)) begin
							leaf_q <= '0;
							cur_q <= '0;
							code_q <= '0;
							len_q <= '0;
							st_q <= ST_WALK;
						end else st_q <= ST_SCAN;
					end else idx_q <= idx_q + 1'b1;
				end
				ST_SCAN: begin
					if (free_i) begin
						if (!ha_q || wi < wa_q) begin
							a_q <= idx_q; wa_q <= wi; ha_q <= 1'b1;
							b_q <= a_q; wb_q <= wa_q; hb_q <= ha_q;
						end else if (!hb_q || wi < wb_q) begin
							b_q <= idx_q; wb_q <= wi; hb_q <= 1'b1;
						end
					end
					if (idx_q + 1'b1 == nxt_q) st_q <= ST_MERGE;
					else idx_q <= idx_q + 1'b1;
				end
				ST_MERGE: begin
					par_q[a_q] <= nxt_q;
					par_q[b_q] <= nxt_q;
					nxt_q <= nxt_q + 1'b1;
					idx_q <= '0;
					ha_q <= 1'b0;
					hb_q <= 1'b0;
					if (nxt_q + 1'b1 == NW'(2 * n_q - 1)) begin
						leaf_q <= '0;
						cur_q <= '0;
						code_q <= '0;
						len_q <= '0;
						st_q <= ST_WALK;
					end else st_q <= ST_SCAN;
				end
				ST_WALK: begin
					if (up != '0) begin
						if (left_q[up] != cur_q && len_q < 6'(CODE_W))
							code_q[len_q[3:0]] <= 1'b1;
						len_q <= len_q + 1'b1;
						cur_q <= up;
					end else st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!ov_q || out_ch.ready) begin
						ov_q <= 1'b1;
						ob_q.symbol <= SYM_W'(leaf_q);
						ob_q.code_bits <= code_q;
						ob_q.code_len <= len_q[LEN_W-1:0];
						ob_q.last_code <= (leaf_q + 1'b1 == n_q);
						if (leaf_q + 1'b1 == n_q) st_q <= ST_WAIT;
						else begin
							leaf_q <= leaf_q + 1'b1;
							cur_q <= NW'(leaf_q + 1'b1);
							code_q <= '0;
							len_q <= '0;
							st_q <= ST_WALK;
						end
					end
				end
				ST_WAIT: st_q <= ST_LOAD;
				default: st_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ===== rtl/huffman_code_builder.sv =====
// Top level of the Huffman code builder: front queue plus build/emit engine.
// Depends on hcb_pkg, hcb_if, hcb_front and hcb_back.
//
// Usage: send leaf weights on in_ch, one per beat; the beat with last set
// closes the set and starts the build. Weights past MAX_SYMBOLS are dropped,
// though their last bit still starts the build. Results leave on out_ch, one
// beat per leaf in load order, last_code on the final one.
// Flow: a weight beat is taken into a four-entry queue. The build clears
// 2*MAX_SYMBOLS-1 parent entries, then for merge k of n-1 scans the n+k
// nodes made so far, one node a cycle, and merges the two lightest; then it
// walks each leaf up to the root, one level a cycle, emits its code, and
// after the last leaf passes through an idle state before loading again.
// The serial scan sets throughput: the engine takes no new weight from the
// queue until the last code of the previous set is in its output register.
// Reset clears the queue, the leaf count and all parent links.
// A stalled receiver holds the output register; the next emit waits behind
// it, and the input keeps filling the queue until it is full.
module huffman_code_builder #(
	parameter int MAX_SYMBOLS = 16,
	parameter int WEIGHT_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	hcb_in_if.sink    in_ch,
	hcb_out_if.source out_ch
);
	import hcb_pkg::*;
	logic q_valid, q_pop, q_last;
	logic [WEIGHT_BITS-1:0] q_weight;

	hcb_front #(.WEIGHT_BITS(WEIGHT_BITS), .QDEPTH(4)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_valid(q_valid), .q_pop(q_pop), .q_weight(q_weight), .q_last(q_last)
	);

	hcb_back #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_weight(q_weight), .q_last(q_last),
		.out_ch(out_ch)
	);
endmodule

// ===== rtl/hcb_checker.sv =====
// Port-level checker for the Huffman code builder, bound to the top level.
// Depends on hcb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hcb_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input hcb_pkg::out_beat_t out_data
);
	import hcb_pkg::*;
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data), "output beat dropped while stalled")
	`CHK_NEXT(a_sym_step, clk, arst_n, out_valid && out_ready && !out_data.last_code,
		!out_valid || out_data.symbol != '0, "symbol restarted mid job")
	`CHK_IMPL(a_first_sym, clk, arst_n,
		out_valid && out_data.symbol == '0 && out_data.code_len == '0,
		out_data.last_code, "zero length code on a multi leaf job")
	`CHK_IMPL(a_code_fit, clk, arst_n, out_valid && out_data.code_len < 4'd15,
		(out_data.code_bits >> out_data.code_len) == '0, "code bits beyond length")
endmodule

bind huffman_code_builder hcb_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
